>>> rtl/core/tpeq_pkg.sv
// shared types, constants and codes of the two-priority event queue
package tpeq_pkg;

  localparam int LOW_DEPTH         = 16;
  localparam int HIGH_DEPTH        = 16;
  localparam int MAX_SUBSCRIBERS   = 16;
  localparam int MAX_TIMER_CLIENTS = 4;

  localparam int LPTR_W = $clog2(2 * LOW_DEPTH);
  localparam int LIDX_W = $clog2(LOW_DEPTH);
  localparam int HPTR_W = $clog2(2 * HIGH_DEPTH);
  localparam int HIDX_W = $clog2(HIGH_DEPTH);

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_POLL    = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_POPPED  = 3'd1;
  localparam logic [2:0] ST_SENT    = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_STARTED = 3'd4;
  localparam logic [2:0] ST_TICKS   = 3'd5;

  localparam logic [2:0] REG_TIMER_PERIOD   = 3'd0;
  localparam logic [2:0] REG_TIMER_CLIENTS  = 3'd1;
  localparam logic [2:0] REG_TIMER_IDS      = 3'd2;
  localparam logic [2:0] REG_SUB_COUNT      = 3'd3;
  localparam logic [2:0] REG_SUB_IDS_LOW    = 3'd4;
  localparam logic [2:0] REG_SUB_IDS_HIGH   = 3'd5;
  localparam logic [2:0] REG_REQUEST_TYPE   = 3'd6;
  localparam logic [2:0] REG_TIMER_CODES    = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [7:0]  event_type;
    logic [7:0]  service;
    logic [7:0]  event_id;
    logic [15:0] arg_x;
    logic [7:0]  arg_y;
    logic [7:0]  arg_z;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_type;
    logic [7:0]  out_service;
    logic [7:0]  out_event_id;
    logic [15:0] out_x;
    logic [7:0]  out_y;
    logic [7:0]  out_z;
    logic        matched;
    logic [3:0]  subscriber_index;
    logic [15:0] missed_ticks;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  ev_type;
    logic [7:0]  service;
    logic [7:0]  event_id;
    logic [15:0] x;
    logic [7:0]  y;
    logic [7:0]  z;
  } ev_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/core/tpeq_div.sv
// restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle
module tpeq_div (
  input  logic               clk,
  input  logic               rst,
  input  tpeq_pkg::div_req_t req,
  output tpeq_pkg::div_rsp_t rsp
);
  import tpeq_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          dvd;
  logic [15:0]          rem;
  logic [15:0]          dvs;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        qbit;
  logic [15:0] rem_next;

  always_comb begin
    trial = {rem, dvd[31]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
    rem_next = qbit ? diff[15:0] : trial[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        // quotient bits fill the dividend register from the bottom
        dvd <= {dvd[30:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule

>>> rtl/core/two_priority_event_queue_with_timer_top.sv
// two-priority event queue with periodic timer: rings, timer and control
//
//  channel  direction  handshake            word
//  in       in         in_valid / in_stall   in_data   (in_word_t)
//  out      out        out_valid / out_stall out_data  (out_word_t)
//  cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// send, start timer and an empty poll finish in the execute state; a pop goes on
// through ring read, subscriber compare and priority encode. a due poll queues a tick
// per client; catch-up needs the serial divider for the count of missed periods.
// reset is synchronous; the rings need no clearing pass since a slot is only read
// after it was written. a new word is taken while the last result waits on out_stall.
module two_priority_event_queue_with_timer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tpeq_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tpeq_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import tpeq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_MATCH = 9'b000001000,
    S_TICK  = 9'b000010000,
    S_ADV1  = 9'b000100000,
    S_ADV2  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic [15:0]  timer_period;
  logic [2:0]   timer_client_count;
  logic [31:0]  timer_client_ids;
  logic [4:0]   subscriber_count;
  logic [127:0] sub_tab;
  logic [7:0]   request_type_code;
  logic [15:0]  timer_event_codes;

  in_word_t  req;
  out_word_t res;
  out_word_t res_out;
  logic [2:0] ex_status;
  logic       out_load;

  logic [LPTR_W-1:0] lwp, lrp;
  logic [HPTR_W-1:0] hwp, hrp;
  logic [31:0]       next_due;
  logic              running;
  logic [15:0]       missed;
  logic [2:0]        tick_i;
  logic [33:0]       dsum;
  logic [MAX_SUBSCRIBERS-1:0] match_vec;
  logic              rd_high;

  // ring memories
  ev_t low_mem  [LOW_DEPTH];
  ev_t high_mem [HIGH_DEPTH];
  ev_t l_rdata, h_rdata;
  logic l_we, h_we;
  ev_t  l_wd, h_wd;

  // ring status
  logic [LPTR_W:0]   l_fill;
  logic [HPTR_W:0]   h_fill;
  logic              l_full, h_full, l_empty, h_empty;
  logic [LIDX_W-1:0] l_widx, l_ridx;
  logic [HIDX_W-1:0] h_widx, h_ridx;
  logic [LPTR_W-1:0] lwp_inc, lrp_inc;
  logic [HPTR_W-1:0] hwp_inc, hrp_inc;

  logic [2:0] n_cli;
  logic [4:0] n_sub;
  logic       to_low;
  logic       due;
  ev_t        send_ev, tick_ev, pop_ev;
  logic       tick_push;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [17:0] missed_sum;

  logic [3:0] first_idx;

  always_comb begin
    l_fill = {1'b0, lwp} - {1'b0, lrp};
    if (lwp < lrp) l_fill = l_fill + (LPTR_W+1)'(2 * LOW_DEPTH);
    h_fill = {1'b0, hwp} - {1'b0, hrp};
    if (hwp < hrp) h_fill = h_fill + (HPTR_W+1)'(2 * HIGH_DEPTH);
    l_full  = (l_fill == (LPTR_W+1)'(LOW_DEPTH));
    h_full  = (h_fill == (HPTR_W+1)'(HIGH_DEPTH));
    l_empty = (lwp == lrp);
    h_empty = (hwp == hrp);

    l_widx = (lwp >= LPTR_W'(LOW_DEPTH)) ? LIDX_W'(lwp - LPTR_W'(LOW_DEPTH)) : LIDX_W'(lwp);
    l_ridx = (lrp >= LPTR_W'(LOW_DEPTH)) ? LIDX_W'(lrp - LPTR_W'(LOW_DEPTH)) : LIDX_W'(lrp);
    h_widx = (hwp >= HPTR_W'(HIGH_DEPTH)) ? HIDX_W'(hwp - HPTR_W'(HIGH_DEPTH))
                                          : HIDX_W'(hwp);
    h_ridx = (hrp >= HPTR_W'(HIGH_DEPTH)) ? HIDX_W'(hrp - HPTR_W'(HIGH_DEPTH))
                                          : HIDX_W'(hrp);

    lwp_inc = (lwp == LPTR_W'(2 * LOW_DEPTH - 1)) ? '0 : lwp + 1'b1;
    lrp_inc = (lrp == LPTR_W'(2 * LOW_DEPTH - 1)) ? '0 : lrp + 1'b1;
    hwp_inc = (hwp == HPTR_W'(2 * HIGH_DEPTH - 1)) ? '0 : hwp + 1'b1;
    hrp_inc = (hrp == HPTR_W'(2 * HIGH_DEPTH - 1)) ? '0 : hrp + 1'b1;
  end

  always_comb begin
    n_cli = (timer_client_count > 3'(MAX_TIMER_CLIENTS)) ? 3'(MAX_TIMER_CLIENTS)
                                                         : timer_client_count;
    n_sub = (subscriber_count > 5'(MAX_SUBSCRIBERS)) ? 5'(MAX_SUBSCRIBERS)
                                                     : subscriber_count;
    to_low = (req.event_type == request_type_code);
    due    = running && (req.now_ms >= next_due);

    send_ev.ev_type  = req.event_type;
    send_ev.service  = req.service;
    send_ev.event_id = req.event_id;
    send_ev.x        = req.arg_x;
    send_ev.y        = req.arg_y;
    send_ev.z        = req.arg_z;

    tick_ev.ev_type  = timer_event_codes[7:0];
    tick_ev.event_id = timer_event_codes[15:8];
    tick_ev.service  = timer_client_ids[8*tick_i[1:0] +: 8];
    tick_ev.x        = '0;
    tick_ev.y        = '0;
    tick_ev.z        = '0;

    tick_push = (state == S_TICK) && (tick_i < n_cli);

    l_we = (state == S_EXEC) && (req.cmd == CMD_SEND) && to_low && !l_full;
    l_wd = send_ev;
    h_we = 1'b0;
    h_wd = send_ev;
    if ((state == S_EXEC) && (req.cmd == CMD_SEND) && !to_low && !h_full) h_we = 1'b1;
    if (tick_push && !h_full) begin
      h_we = 1'b1;
      h_wd = tick_ev;
    end

    pop_ev = rd_high ? h_rdata : l_rdata;
  end

  // status of the commands that finish in the execute cycle
  always_comb begin
    ex_status = ST_NONE;
    case (req.cmd)
      CMD_SEND:  ex_status = (to_low ? l_full : h_full) ? ST_DROPPED : ST_SENT;
      CMD_START: ex_status = ST_STARTED;
      default: ;
    endcase
  end

  always_comb begin
    res_out              = res;
    res_out.missed_ticks = missed;
    out_load             = (state == S_DONE) && (!out_valid || !out_stall);
  end

  // the read port follows the read pointer, so data is ready the cycle after a pop
  always_ff @(posedge clk) begin
    if (l_we) low_mem[l_widx] <= l_wd;
    l_rdata <= low_mem[l_ridx];
  end

  always_ff @(posedge clk) begin
    if (h_we) high_mem[h_widx] <= h_wd;
    h_rdata <= high_mem[h_ridx];
  end

  always_comb begin
    first_idx = '0;
    for (int k = MAX_SUBSCRIBERS - 1; k >= 0; k--) begin
      if (match_vec[k]) first_idx = 4'(k);
    end
  end

  always_comb begin
    div_req.start    = (state == S_ADV2) && ({2'b0, req.now_ms} >= dsum);
    div_req.dividend = req.now_ms - dsum[31:0];
    div_req.divisor  = timer_period;
    missed_sum = 18'(missed) + 18'(div_rsp.quot[15:0]) + 18'd1;
  end

  tpeq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period       <= '0;
      timer_client_count <= '0;
      timer_client_ids   <= '0;
      subscriber_count   <= '0;
      sub_tab            <= '0;
      request_type_code  <= '0;
      timer_event_codes  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMER_PERIOD:  timer_period       <= cfg_data[15:0];
        REG_TIMER_CLIENTS: timer_client_count <= cfg_data[2:0];
        REG_TIMER_IDS:     timer_client_ids   <= cfg_data[31:0];
        REG_SUB_COUNT:     subscriber_count   <= cfg_data[4:0];
        REG_SUB_IDS_LOW:   sub_tab[63:0]      <= cfg_data;
        REG_SUB_IDS_HIGH:  sub_tab[127:64]    <= cfg_data;
        REG_REQUEST_TYPE:  request_type_code  <= cfg_data[7:0];
        REG_TIMER_CODES:   timer_event_codes  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lwp       <= '0;
      lrp       <= '0;
      hwp       <= '0;
      hrp       <= '0;
      next_due  <= '0;
      running   <= 1'b0;
      missed    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (l_we) lwp <= lwp_inc;
      if (h_we) hwp <= hwp_inc;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          res   <= {ex_status, {($bits(out_word_t) - 3){1'b0}}};
          state <= S_DONE;
          case (req.cmd)
            CMD_POLL: begin
              if (!h_empty) begin
                hrp     <= hrp_inc;
                rd_high <= 1'b1;
                state   <= S_READ;
              end else if (due) begin
                tick_i <= '0;
                state  <= S_TICK;
              end else if (!l_empty) begin
                lrp     <= lrp_inc;
                rd_high <= 1'b0;
                state   <= S_READ;
              end
            end
            CMD_START: begin
              next_due <= req.now_ms + 32'(timer_period);
              running  <= 1'b1;
            end
            default: ;
          endcase
        end

        S_READ: begin
          res.status       <= ST_POPPED;
          res.out_type     <= pop_ev.ev_type;
          res.out_service  <= pop_ev.service;
          res.out_event_id <= pop_ev.event_id;
          res.out_x        <= pop_ev.x;
          res.out_y        <= pop_ev.y;
          res.out_z        <= pop_ev.z;
          for (int k = 0; k < MAX_SUBSCRIBERS; k++) begin
            match_vec[k] <= (5'(k) < n_sub) && (sub_tab[8*k +: 8] == pop_ev.service);
          end
          state <= S_MATCH;
        end

        S_MATCH: begin
          res.matched          <= |match_vec;
          res.subscriber_index <= first_idx;
          state                <= S_DONE;
        end

        S_TICK: begin
          res.status <= ST_TICKS;
          if (tick_push) begin
            tick_i <= tick_i + 1'b1;
          end else if (timer_period == '0) begin
            state <= S_DONE;
          end else begin
            dsum  <= {2'b0, next_due} + 34'(timer_period);
            state <= S_ADV1;
          end
        end

        S_ADV1: begin
          if ({2'b0, req.now_ms} >= dsum) begin
            dsum  <= dsum + 34'(timer_period);
            state <= S_ADV2;
          end else begin
            next_due <= dsum[31:0];
            state    <= S_DONE;
          end
        end

        S_ADV2: begin
          if (div_req.start) begin
            state <= S_DIV;
          end else begin
            next_due <= dsum[31:0];
            state    <= S_DONE;
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            // whole periods past the second step land just beyond now
            next_due <= req.now_ms - 32'(div_rsp.rem) + 32'(timer_period);
            if ((|div_rsp.quot[31:16]) || (|missed_sum[17:16])) missed <= '1;
            else missed <= missed_sum[15:0];
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_load) begin
            out_data <= res_out;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (state == S_IDLE))
    else $error("word taken while busy");

  a_low_fill: assert property (@(posedge clk) disable iff (rst)
    l_fill <= (LPTR_W+1)'(LOW_DEPTH))
    else $error("low ring over-filled");

  a_high_fill: assert property (@(posedge clk) disable iff (rst)
    h_fill <= (HPTR_W+1)'(HIGH_DEPTH))
    else $error("high ring over-filled");

  a_match_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_POPPED) |-> !out_data.matched)
    else $error("match flagged without pop");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside catch-up");

endmodule

>>> verif/tb_two_priority_event_queue_with_timer_top.sv
// testbench of the two-priority event queue: directed table, random traffic, predictor check
module tb_two_priority_event_queue_with_timer_top;
  import tpeq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS   = 1400;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  two_priority_event_queue_with_timer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] q_period;
  logic [2:0]  q_clients;
  logic [31:0] q_client_ids;
  logic [4:0]  q_sub_count;
  logic [63:0] q_sub_low;
  logic [63:0] q_sub_high;
  logic [7:0]  q_req_type;
  logic [15:0] q_tick_codes;
  ev_t         q_low_ring [LOW_DEPTH];
  ev_t         q_high_ring [HIGH_DEPTH];
  logic [LPTR_W-1:0] q_lw, q_lr;
  logic [HPTR_W-1:0] q_hw, q_hr;
  logic [31:0] q_due;
  logic        q_running;
  logic [15:0] q_missed;

  out_word_t expected_words [$];
  int errors;
  int idle_count;
  // idle percentages of sender and receiver
  int send_mode;
  int stall_mode;
  int long_hold;
  int pops_seen;
  int ticks_seen;
  int drops_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [LPTR_W-1:0] low_fill();
    return q_lw - q_lr;
  endfunction

  function automatic logic [HPTR_W-1:0] high_fill();
    return q_hw - q_hr;
  endfunction

  function automatic bit push_high(ev_t e);
    if (high_fill() >= HIGH_DEPTH) return 1'b0;
    q_high_ring[q_hw[HIDX_W-1:0]] = e;
    q_hw = q_hw + 1'b1;
    return 1'b1;
  endfunction

  function automatic bit push_low(ev_t e);
    if (low_fill() >= LOW_DEPTH) return 1'b0;
    q_low_ring[q_lw[LIDX_W-1:0]] = e;
    q_lw = q_lw + 1'b1;
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] v);
    case (idx)
      REG_TIMER_PERIOD:  q_period = v[15:0];
      REG_TIMER_CLIENTS: q_clients = v[2:0];
      REG_TIMER_IDS:     q_client_ids = v[31:0];
      REG_SUB_COUNT:     q_sub_count = v[4:0];
      REG_SUB_IDS_LOW:   q_sub_low = v;
      REG_SUB_IDS_HIGH:  q_sub_high = v;
      REG_REQUEST_TYPE:  q_req_type = v[7:0];
      REG_TIMER_CODES:   q_tick_codes = v[15:0];
      default: ;
    endcase
  endfunction

  function automatic void fire_ticks(logic [31:0] now);
    int n;
    ev_t t;
    logic [63:0] d, p, k, m;
    bit ok;
    n = (q_clients > MAX_TIMER_CLIENTS) ? MAX_TIMER_CLIENTS : int'(q_clients);
    for (int i = 0; i < n; i++) begin
      t = '0;
      t.ev_type = q_tick_codes[7:0];
      t.event_id = q_tick_codes[15:8];
      t.service = q_client_ids[8*i +: 8];
      ok = push_high(t);
    end
    p = 64'(q_period);
    if (p == 0) return;
    d = 64'(q_due) + p;
    if (64'(now) >= d) d = d + p;
    if (64'(now) >= d) begin
      k = (64'(now) - d) / p + 64'd1;
      m = 64'(q_missed) + k;
      d = d + k * p;
      q_missed = (m > 64'hFFFF) ? 16'hFFFF : m[15:0];
    end
    q_due = d[31:0];
  endfunction

  // one input word in, one expected result out
  function automatic out_word_t queue_step(in_word_t w);
    out_word_t r;
    ev_t e;
    bit popped, ok;
    int n;
    logic [7:0] sid;
    r = '0;
    popped = 1'b0;
    e = '0;
    case (w.cmd)
      CMD_SEND: begin
        e.ev_type = w.event_type; e.service = w.service; e.event_id = w.event_id;
        e.x = w.arg_x; e.y = w.arg_y; e.z = w.arg_z;
        ok = (e.ev_type == q_req_type) ? push_low(e) : push_high(e);
        r.status = ok ? ST_SENT : ST_DROPPED;
      end
      CMD_POLL: begin
        if (high_fill() != 0) begin
          e = q_high_ring[q_hr[HIDX_W-1:0]];
          q_hr = q_hr + 1'b1;
          popped = 1'b1;
        end else if (q_running && w.now_ms >= q_due) begin
          fire_ticks(w.now_ms);
          r.status = ST_TICKS;
        end else if (low_fill() != 0) begin
          e = q_low_ring[q_lr[LIDX_W-1:0]];
          q_lr = q_lr + 1'b1;
          popped = 1'b1;
        end
      end
      CMD_START: begin
        q_due = w.now_ms + 32'(q_period);
        q_running = 1'b1;
        r.status = ST_STARTED;
      end
      default: ;
    endcase
    if (popped) begin
      r.status = ST_POPPED;
      r.out_type = e.ev_type; r.out_service = e.service; r.out_event_id = e.event_id;
      r.out_x = e.x; r.out_y = e.y; r.out_z = e.z;
      n = (q_sub_count > MAX_SUBSCRIBERS) ? MAX_SUBSCRIBERS : int'(q_sub_count);
      for (int i = 0; i < n; i++) begin
        sid = (i < 8) ? q_sub_low[8*i +: 8] : q_sub_high[8*(i-8) +: 8];
        if (sid == e.service) begin
          r.matched = 1'b1;
          r.subscriber_index = i[3:0];
          break;
        end
      end
    end
    r.missed_ticks = q_missed;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_word(in_word_t w, bit has_typed, out_word_t typed);
    out_word_t p;
    cfg_valid <= 1'b0;
    while (send_mode != 0 && $urandom_range(99) < send_mode) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = queue_step(w);
    if (has_typed && p != typed) begin
      $error("table row mismatch with predictor: %h vs %h", typed, p);
      errors++;
    end
    expected_words.push_back(has_typed ? typed : p);
  endtask

  function automatic in_word_t make_word(logic [1:0] c, logic [31:0] now, logic [7:0] ty,
                                         logic [7:0] sv);
    in_word_t w;
    w.cmd = c; w.now_ms = now; w.event_type = ty; w.service = sv;
    w.event_id = 8'($urandom); w.arg_x = 16'($urandom);
    w.arg_y = 8'($urandom); w.arg_z = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t random_word(logic [31:0] now);
    in_word_t w;
    int r;
    r = $urandom_range(99);
    w = make_word(CMD_SEND, now, 8'($urandom), 8'($urandom));
    if (r < 40) begin
      if ($urandom_range(1)) w.event_type = q_req_type;
      if ($urandom_range(1)) w.service = q_sub_low[8*$urandom_range(7) +: 8];
    end else if (r < 88) w.cmd = CMD_POLL;
    else if (r < 96) w.cmd = CMD_START;
    else w.cmd = CMD_UNKNOWN;
    return w;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold <= long_hold - 1;
    end else if (stall_mode != 0) begin
      out_stall <= ($urandom_range(99) < stall_mode);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    out_word_t x;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_count <= 0;
      else
        idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress, %0d results outstanding", expected_words.size());
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", out_data);
          errors++;
        end else begin
          x = expected_words.pop_front();
          if (x.status == ST_POPPED) pops_seen++;
          if (x.status == ST_TICKS) ticks_seen++;
          if (x.status == ST_DROPPED) drops_seen++;
          if (out_data.status != x.status) begin
            $error("status exp %0d got %0d", x.status, out_data.status); errors++;
          end
          if (out_data.out_type != x.out_type) begin
            $error("out_type exp %h got %h", x.out_type, out_data.out_type); errors++;
          end
          if (out_data.out_service != x.out_service) begin
            $error("out_service exp %h got %h", x.out_service, out_data.out_service); errors++;
          end
          if (out_data.out_event_id != x.out_event_id) begin
            $error("out_event_id exp %h got %h", x.out_event_id, out_data.out_event_id);
            errors++;
          end
          if (out_data.out_x != x.out_x) begin
            $error("out_x exp %h got %h", x.out_x, out_data.out_x); errors++;
          end
          if (out_data.out_y != x.out_y) begin
            $error("out_y exp %h got %h", x.out_y, out_data.out_y); errors++;
          end
          if (out_data.out_z != x.out_z) begin
            $error("out_z exp %h got %h", x.out_z, out_data.out_z); errors++;
          end
          if (out_data.matched != x.matched) begin
            $error("matched exp %0d got %0d", x.matched, out_data.matched); errors++;
          end
          if (out_data.subscriber_index != x.subscriber_index) begin
            $error("subscriber_index exp %0d got %0d", x.subscriber_index,
                   out_data.subscriber_index); errors++;
          end
          if (out_data.missed_ticks != x.missed_ticks) begin
            $error("missed_ticks exp %0d got %0d", x.missed_ticks, out_data.missed_ticks);
            errors++;
          end
        end
      end
    end
  end

  typedef struct {
    in_word_t w;
    bit       typed;
    out_word_t r;
  } row_t;

  initial begin
    row_t rows [$];
    row_t rw;
    in_word_t w;
    out_word_t z;
    logic [31:0] now;
    int phase;

    errors = 0; idle_count = 0; send_mode = 0; stall_mode = 0; long_hold = 0;
    pops_seen = 0; ticks_seen = 0; drops_seen = 0;
    q_period = 0; q_clients = 0; q_client_ids = 0; q_sub_count = 0;
    q_sub_low = 0; q_sub_high = 0; q_req_type = 0; q_tick_codes = 0;
    q_lw = 0; q_lr = 0; q_hw = 0; q_hr = 0; q_due = 0; q_running = 0; q_missed = 0;
    rst = 1'b1; in_valid = 1'b0; in_data = '0; cfg_valid = 1'b0; cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty poll after reset, unknown command, two sends, start with zero period
    z = '0;
    rw.w = make_word(CMD_POLL, 32'hFFFF_FFFF, 8'h00, 8'h00); rw.typed = 1; rw.r = z;
    rows.push_back(rw);
    rw.w = make_word(CMD_UNKNOWN, 32'h0, 8'hFF, 8'hFF); rw.typed = 1; rows.push_back(rw);
    rw.w = make_word(CMD_SEND, 32'h0, 8'h00, 8'hFF); rw.typed = 1; z.status = ST_SENT;
    rw.r = z; rows.push_back(rw);
    rw.w = make_word(CMD_SEND, 32'h0, 8'hFF, 8'h00); rows.push_back(rw);
    rw.w = make_word(CMD_START, 32'hFFFF_FFFF, 8'h00, 8'h00); z.status = ST_STARTED;
    rw.r = z; rows.push_back(rw);
    // zero period: due poll queues no ticks (no clients) and keeps the due time
    rw.w = make_word(CMD_POLL, 32'h0, 8'h00, 8'h00); rw.typed = 0; rows.push_back(rw);
    rw.w = make_word(CMD_POLL, 32'h0, 8'h00, 8'h00); rows.push_back(rw);
    rw.w = make_word(CMD_POLL, 32'hFFFF_FFFF, 8'h00, 8'h00); rows.push_back(rw);
    rw.w = make_word(CMD_POLL, 32'hFFFF_FFFF, 8'h00, 8'h00); rows.push_back(rw);
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);
    drain();

    // every register, counts above the tables, extreme period
    write_reg(REG_TIMER_PERIOD, 64'd1);
    write_reg(REG_TIMER_CLIENTS, 64'd7);
    write_reg(REG_TIMER_IDS, 64'h0403_0201);
    write_reg(REG_SUB_COUNT, 64'd31);
    write_reg(REG_SUB_IDS_LOW, 64'h0706_0504_0302_0100);
    write_reg(REG_SUB_IDS_HIGH, 64'hFF0E_0D0C_0B0A_0908);
    write_reg(REG_REQUEST_TYPE, 64'hAA);
    write_reg(REG_TIMER_CODES, 64'h55C3);
    // ring full: high and low each filled past depth, catch-up with period one
    for (int i = 0; i < 18; i++) send_word(make_word(CMD_SEND, 0, 8'h11, i[7:0]), 0, z);
    for (int i = 0; i < 18; i++) send_word(make_word(CMD_SEND, 0, 8'hAA, 8'hFF), 0, z);
    send_word(make_word(CMD_START, 32'd100, 8'h00, 8'h00), 0, z);
    for (int i = 0; i < 40; i++) begin
      send_word(make_word(CMD_POLL, 32'd100000, 8'h00, 8'h00), 0, z);
    end
    drain();

    now = 0;
    for (phase = 0; phase < 7; phase++) begin
      case (phase % 4)
        0: begin send_mode = 0; stall_mode = 0; end
        1: begin send_mode = 54; stall_mode = 0; end
        2: begin send_mode = 0; stall_mode = 54; end
        default: begin send_mode = 29; stall_mode = 29; end
      endcase
      if (phase == 6) begin
        write_reg(REG_TIMER_PERIOD, 64'hFFFF);
        write_reg(REG_TIMER_CLIENTS, 64'd4);
      end else begin
        write_reg(REG_TIMER_PERIOD, (phase == 0) ? 64'd0 : 64'($urandom_range(400, 1)));
        write_reg(REG_TIMER_CLIENTS, 64'($urandom_range(4)));
      end
      write_reg(REG_TIMER_IDS, {$urandom, $urandom});
      write_reg(REG_SUB_COUNT, 64'($urandom_range(16)));
      write_reg(REG_SUB_IDS_LOW, {$urandom, $urandom});
      write_reg(REG_SUB_IDS_HIGH, {$urandom, $urandom});
      write_reg(REG_REQUEST_TYPE, 64'($urandom));
      write_reg(REG_TIMER_CODES, 64'($urandom));
      if (phase == 3) long_hold = 400;
      for (int i = 0; i < RANDOM_WORDS / 7; i++) begin
        if ($urandom_range(49) == 0) now = $urandom;
        else now = now + $urandom_range(300);
        w = random_word(now);
        send_word(w, 0, z);
      end
      // sender pause until every result is back
      drain();
    end
    drain();
    $display("covered %0d pops, %0d tick passes, %0d dropped sends over 7 settings",
             pops_seen, ticks_seen, drops_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
